FILE: design/register_table_access_slave_unit_assert.svh
// Assertion macros shared by the register table access slave unit.
`ifndef REGISTER_TABLE_ACCESS_SLAVE_UNIT_ASSERT_SVH
`define REGISTER_TABLE_ACCESS_SLAVE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication: when a holds, c must hold too.
`define RTAS_ASSERT_IMPLY(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("rtas: same-cycle check failed");
// Next-cycle implication: when a holds, c must hold in the next cycle.
`define RTAS_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("rtas: next-cycle check failed");
`else
`define RTAS_ASSERT_IMPLY(label, clk, rst, a, c)
`define RTAS_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

FILE: design/rtas_pkg.sv
// Package: shared types and codes for the register table access slave.
`timescale 1ns / 1ps
package rtas_pkg;

   // Configuration port address width (four 32-bit registers)
   localparam int CSR_ADDR_W = 4;

   // Request modes
   localparam logic [2:0] MODE_RD1  = 3'd0;
   localparam logic [2:0] MODE_RD2  = 3'd1;
   localparam logic [2:0] MODE_WR1  = 3'd2;
   localparam logic [2:0] MODE_WR2  = 3'd3;
   localparam logic [2:0] MODE_PING = 3'd4;

   // Reply kinds
   localparam logic [2:0] KIND_RD1  = 3'd0;
   localparam logic [2:0] KIND_RD2  = 3'd1;
   localparam logic [2:0] KIND_WR1  = 3'd2;
   localparam logic [2:0] KIND_WR2  = 3'd3;
   localparam logic [2:0] KIND_PING = 3'd4;
   localparam logic [2:0] KIND_ERR  = 3'd5;

   // Error codes carried in word zero of an error frame
   localparam logic [15:0] CODE_BLOCKED   = 16'd0;
   localparam logic [15:0] CODE_BADADDR   = 16'd1;
   localparam logic [15:0] CODE_PROTECTED = 16'd2;

   typedef struct packed {
      logic [2:0]  mode;
      logic        block_state_changes;
      logic [15:0] first_address;
      logic [15:0] first_data;
      logic [15:0] second_address;
      logic [15:0] second_data;
   } req_type;

   typedef struct packed {
      logic [2:0]  reply_kind;
      logic [15:0] word_zero;
      logic [15:0] word_one;
      logic [15:0] word_two;
      logic [15:0] word_three;
   } rsp_type;

   typedef struct packed {
      logic [8:0]  table_size;
      logic        protect_enable;
      logic [15:0] protect_low;
      logic [15:0] protect_high;
   } cfg_type;

   // Which reply frame the current transaction produces
   typedef enum logic [2:0] {
      FRAME_ACK,
      FRAME_BLOCKED,
      FRAME_BAD_FIRST,
      FRAME_BAD_SECOND,
      FRAME_PROT_FIRST,
      FRAME_PROT_SECOND
   } frame_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_RD_A,
      ST_RD_B,
      ST_RD_C,
      ST_WR_A,
      ST_WR_B,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic          clear;
      logic          load_req;
      logic          mem_rd;
      logic          rd_second;
      logic          mem_wr;
      logic          wr_second;
      logic          cap_first;
      logic          cap_second;
      logic          set_frame;
      frame_sel_type frame;
      logic          push;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic       clear_last;
      logic [2:0] mode;
      logic       blocked;
      logic       first_ok;
      logic       second_ok;
      logic       first_prot;
      logic       second_prot;
      logic       out_free;
   } sts_type;

endpackage

FILE: design/rtas_if.sv
// Interfaces: request and reply channels with valid/ready handshake.
`timescale 1ns / 1ps
interface rtas_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic        block_state_changes;
   logic [15:0] first_address;
   logic [15:0] first_data;
   logic [15:0] second_address;
   logic [15:0] second_data;

   modport source (
      output valid, mode, block_state_changes, first_address, first_data,
             second_address, second_data,
      input  ready
   );
   modport sink (
      input  valid, mode, block_state_changes, first_address, first_data,
             second_address, second_data,
      output ready
   );
endinterface

interface rtas_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  reply_kind;
   logic [15:0] word_zero;
   logic [15:0] word_one;
   logic [15:0] word_two;
   logic [15:0] word_three;

   modport source (
      output valid, reply_kind, word_zero, word_one, word_two, word_three,
      input  ready
   );
   modport sink (
      input  valid, reply_kind, word_zero, word_one, word_two, word_three,
      output ready
   );
endinterface

FILE: design/rtas_csr.sv
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module rtas_csr
   import rtas_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   localparam logic [1:0] REG_TABLE_SIZE   = 2'd0;
   localparam logic [1:0] REG_PROT_ENABLE  = 2'd1;
   localparam logic [1:0] REG_PROT_LOW     = 2'd2;
   localparam logic [1:0] REG_PROT_HIGH    = 2'd3;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Next register values
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TABLE_SIZE:  cfg_in.table_size     = csr_pwdata[8:0];
            REG_PROT_ENABLE: cfg_in.protect_enable = csr_pwdata[0];
            REG_PROT_LOW:    cfg_in.protect_low    = csr_pwdata[15:0];
            REG_PROT_HIGH:   cfg_in.protect_high   = csr_pwdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.table_size     <= 9'd256;
         cfg_ff.protect_enable <= 1'b0;
         cfg_ff.protect_low    <= 16'd0;
         cfg_ff.protect_high   <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         REG_TABLE_SIZE:  csr_prdata = {23'd0, cfg_ff.table_size};
         REG_PROT_ENABLE: csr_prdata = {31'd0, cfg_ff.protect_enable};
         REG_PROT_LOW:    csr_prdata = {16'd0, cfg_ff.protect_low};
         REG_PROT_HIGH:   csr_prdata = {16'd0, cfg_ff.protect_high};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/rtas_ctrl.sv
// Controller: sequences the checks, table accesses and reply push.
`timescale 1ns / 1ps
`include "register_table_access_slave_unit_assert.svh"
module rtas_ctrl
   import rtas_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      is_write;
   logic      is_wr2;
   logic      req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign is_write  = (sts.mode == MODE_WR1) || (sts.mode == MODE_WR2);
   assign is_wr2    = (sts.mode == MODE_WR2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.set_frame = 1'b1;
            cmd.frame     = FRAME_ACK;
            state_in      = ST_FINISH;
            if ((sts.mode == MODE_RD1) || (sts.mode == MODE_RD2)) begin
               if (!sts.first_ok) begin
                  cmd.frame = FRAME_BAD_FIRST;
               end else if ((sts.mode == MODE_RD2) && !sts.second_ok) begin
                  cmd.frame = FRAME_BAD_SECOND;
               end else begin
                  state_in = ST_RD_A;
               end
            end else if (is_write) begin
               // blocked, then first address, then second address
               if (sts.blocked) begin
                  cmd.frame = FRAME_BLOCKED;
               end else if (!sts.first_ok) begin
                  cmd.frame = FRAME_BAD_FIRST;
               end else if (sts.first_prot) begin
                  cmd.frame = FRAME_PROT_FIRST;
               end else if (is_wr2 && !sts.second_ok) begin
                  cmd.frame = FRAME_BAD_SECOND;
               end else if (is_wr2 && sts.second_prot) begin
                  cmd.frame = FRAME_PROT_SECOND;
               end else begin
                  state_in = ST_WR_A;
               end
            end else if (sts.mode != MODE_PING) begin
               // unknown mode: drop silently
               cmd.set_frame = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_RD_A: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.cap_first = 1'b1;
            cmd.mem_rd    = 1'b1;
            cmd.rd_second = 1'b1;
            state_in      = (sts.mode == MODE_RD2) ? ST_RD_C : ST_FINISH;
         end
         ST_RD_C: begin
            cmd.cap_second = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_WR_A: begin
            cmd.mem_wr = 1'b1;
            state_in   = is_wr2 ? ST_WR_B : ST_FINISH;
         end
         ST_WR_B: begin
            cmd.mem_wr    = 1'b1;
            cmd.wr_second = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A reply is never pushed over one still waiting
   `RTAS_ASSERT_IMPLY(a_no_overwrite, clock, reset, cmd.push, sts.out_free)
   // An accepted transaction is always checked next
   `RTAS_ASSERT_NEXT(a_accept_to_check, clock, reset, req_fire, state_ff == ST_CHECK)

endmodule

FILE: design/rtas_dp.sv
// Datapath: request capture, address checks, register table and reply register.
`timescale 1ns / 1ps
`include "register_table_access_slave_unit_assert.svh"
module rtas_dp
   import rtas_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
)
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cfg_type cfg,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int          AW      = $clog2(TABLE_DEPTH);
   localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);

   logic [15:0]   mem [TABLE_DEPTH];
   logic [15:0]   rdata_ff;
   logic [AW-1:0] clear_cnt_ff;
   logic [AW-1:0] clear_cnt_in;
   req_type       req_ff;
   frame_sel_type frame_ff;
   logic [15:0]   data1_ff;
   logic [15:0]   data2_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_c;

   logic [16:0]   limit;
   logic [15:0]   wr_addr;
   logic [15:0]   wr_data;
   logic [AW-1:0] mem_waddr;
   logic [15:0]   mem_wdata;
   logic          mem_we;
   logic [AW-1:0] mem_raddr;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req;
      end
      if (cmd.set_frame) begin
         frame_ff <= cmd.frame;
      end
   end

   // Address checks against the active table size and protected range
   assign limit = ({8'd0, cfg.table_size} > DEPTH_W) ? DEPTH_W
                                                     : {8'd0, cfg.table_size};
   assign sts.mode        = req_ff.mode;
   assign sts.blocked     = req_ff.block_state_changes;
   assign sts.first_ok    = {1'b0, req_ff.first_address} < limit;
   assign sts.second_ok   = {1'b0, req_ff.second_address} < limit;
   assign sts.first_prot  = cfg.protect_enable
                            && (req_ff.first_address >= cfg.protect_low)
                            && (req_ff.first_address <= cfg.protect_high);
   assign sts.second_prot = cfg.protect_enable
                            && (req_ff.second_address >= cfg.protect_low)
                            && (req_ff.second_address <= cfg.protect_high);

   // Clearing pass after reset
   assign clear_cnt_in   = cmd.clear ? clear_cnt_ff + 1'b1 : clear_cnt_ff;
   assign sts.clear_last = (clear_cnt_ff == AW'(TABLE_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // Single table write port, shared by clearing and requests
   assign wr_addr   = cmd.wr_second ? req_ff.second_address : req_ff.first_address;
   assign wr_data   = cmd.wr_second ? req_ff.second_data : req_ff.first_data;
   assign mem_we    = cmd.clear || cmd.mem_wr;
   assign mem_waddr = cmd.clear ? clear_cnt_ff : wr_addr[AW-1:0];
   assign mem_wdata = cmd.clear ? 16'd0 : wr_data;
   assign mem_raddr = cmd.rd_second ? req_ff.second_address[AW-1:0]
                                    : req_ff.first_address[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // Read data capture
   always_ff @(posedge clock) begin
      if (cmd.cap_first) begin
         data1_ff <= rdata_ff;
      end
      if (cmd.cap_second) begin
         data2_ff <= rdata_ff;
      end
   end

   // Reply frame assembly
   always_comb begin
      rsp_c = '0;
      rsp_c.reply_kind = KIND_ERR;
      case (frame_ff)
         FRAME_ACK: begin
            case (req_ff.mode)
               MODE_RD1: begin
                  rsp_c.reply_kind = KIND_RD1;
                  rsp_c.word_zero  = req_ff.first_address;
                  rsp_c.word_one   = data1_ff;
               end
               MODE_RD2: begin
                  rsp_c.reply_kind = KIND_RD2;
                  rsp_c.word_zero  = req_ff.first_address;
                  rsp_c.word_one   = data1_ff;
                  rsp_c.word_two   = req_ff.second_address;
                  rsp_c.word_three = data2_ff;
               end
               MODE_WR1: begin
                  rsp_c.reply_kind = KIND_WR1;
                  rsp_c.word_zero  = req_ff.first_address;
               end
               MODE_WR2: begin
                  rsp_c.reply_kind = KIND_WR2;
                  rsp_c.word_zero  = req_ff.first_address;
                  rsp_c.word_one   = req_ff.second_address;
               end
               MODE_PING: begin
                  rsp_c.reply_kind = KIND_PING;
                  rsp_c.word_zero  = req_ff.first_address;
                  rsp_c.word_one   = req_ff.first_data;
                  rsp_c.word_two   = req_ff.second_address;
                  rsp_c.word_three = req_ff.second_data;
               end
               default: begin
                  rsp_c = '0;
               end
            endcase
         end
         FRAME_BLOCKED: begin
            rsp_c.word_zero = CODE_BLOCKED;
         end
         FRAME_BAD_FIRST: begin
            rsp_c.word_zero = CODE_BADADDR;
            rsp_c.word_one  = req_ff.first_address;
         end
         FRAME_BAD_SECOND: begin
            rsp_c.word_zero = CODE_BADADDR;
            rsp_c.word_one  = req_ff.second_address;
         end
         FRAME_PROT_FIRST: begin
            rsp_c.word_zero = CODE_PROTECTED;
            rsp_c.word_one  = req_ff.first_address;
         end
         FRAME_PROT_SECOND: begin
            rsp_c.word_zero = CODE_PROTECTED;
            rsp_c.word_one  = req_ff.second_address;
         end
         default: begin
            rsp_c = '0;
         end
      endcase
   end

   // Reply output register
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = cmd.push ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_ff <= rsp_c;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Request writes only ever reach valid table entries
   `RTAS_ASSERT_IMPLY(a_write_in_range, clock, reset, cmd.mem_wr, {1'b0, wr_addr} < limit)
   // A pushed reply is presented on the next cycle
   `RTAS_ASSERT_NEXT(a_push_sets_valid, clock, reset, cmd.push, rsp_valid_ff)

endmodule

FILE: design/register_table_access_slave_unit.sv
// Accept to reply: CHECK, then RD_A and RD_B (and RD_C for read two) or WR_A (and WR_B for
// write two), none for ping or error; FINISH pushes the reply once the output is free, and
// idle takes the next request. An ignored mode goes from CHECK back to idle, unanswered.
// One table read or write a cycle; a waiting reply blocks only the next push. Reset (sync):
// config to defaults, a clearing pass zeroes the table; CSR writes go on, requests wait.
`timescale 1ns / 1ps
module register_table_access_slave_unit
   import rtas_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
)
(
   input  logic                  clock,
   input  logic                  reset,
   rtas_req_if.sink              req_ch,
   rtas_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;
   req_type req;
   rsp_type rsp;
   logic    req_ready;
   logic    rsp_valid;

   // Channel payload packing
   assign req.mode                = req_ch.mode;
   assign req.block_state_changes = req_ch.block_state_changes;
   assign req.first_address       = req_ch.first_address;
   assign req.first_data          = req_ch.first_data;
   assign req.second_address      = req_ch.second_address;
   assign req.second_data         = req_ch.second_data;
   assign req_ch.ready            = req_ready;

   assign rsp_ch.valid      = rsp_valid;
   assign rsp_ch.reply_kind = rsp.reply_kind;
   assign rsp_ch.word_zero  = rsp.word_zero;
   assign rsp_ch.word_one   = rsp.word_one;
   assign rsp_ch.word_two   = rsp.word_two;
   assign rsp_ch.word_three = rsp.word_three;

   rtas_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rtas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rtas_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .rsp       (rsp)
   );

endmodule

FILE: tb/sv/register_table_access_slave_unit_tb.sv
// Testbench for the register table access slave: directed table, random phases, reply checks.
`timescale 1ns / 1ps
module register_table_access_slave_unit_tb
   import rtas_pkg::*;
();

   localparam int          REG_DEPTH     = 256;
   localparam int unsigned PHASE_ITEMS   = 175;
   localparam int unsigned STALL_LIMIT   = 4000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned END_CYCLES    = 20;
   localparam int unsigned NO_GAP_PHASE  = 4;

   // Modes the block ignores
   localparam logic [2:0] MODE_SPARE_A = 3'd5;
   localparam logic [2:0] MODE_SPARE_B = 3'd6;
   localparam logic [2:0] MODE_SPARE_C = 3'd7;
   localparam logic [2:0] LIVE_MODES [5] = '{MODE_RD1, MODE_RD2, MODE_WR1, MODE_WR2, MODE_PING};

   typedef enum int unsigned {
      CSR_TABLE_SIZE,
      CSR_PROTECT_ENABLE,
      CSR_PROTECT_LOW,
      CSR_PROTECT_HIGH
   } csr_index_type;

   typedef struct {
      bit            is_csr;
      csr_index_type csr_idx;
      logic [31:0]   csr_value;
      req_type       request;
      bit            typed;
      rsp_type       reply;
   } directed_row_type;

   // Raw register values of one phase; upper bits test the masking
   typedef struct {
      logic [31:0] size_raw;
      logic [31:0] enable_raw;
      logic [31:0] low_raw;
      logic [31:0] high_raw;
   } phase_setting_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rtas_req_if req_ch ();
   rtas_rsp_if rsp_ch ();

   // Predictor state: register image and configuration copy
   logic [15:0]       reg_image [REG_DEPTH];
   cfg_type           cfg_image;
   rsp_type           expected_replies [$];
   directed_row_type  directed [$];
   phase_setting_type phase_settings [9];
   bit                allow_gaps;
   int unsigned       error_count;

   register_table_access_slave_unit #(.TABLE_DEPTH(REG_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic rsp_type frame(input logic [2:0] kind, input logic [15:0] w0, w1, w2, w3);
      return {kind, w0, w1, w2, w3};
   endfunction

   function automatic int unsigned table_limit();
      return (cfg_image.table_size > REG_DEPTH) ? REG_DEPTH : cfg_image.table_size;
   endfunction

   // Validity first, then the protected range
   function automatic bit write_refused(input logic [15:0] addr, output rsp_type err);
      err = '0;
      if (addr >= table_limit()) begin
         err = frame(KIND_ERR, CODE_BADADDR, addr, 16'd0, 16'd0);
         return 1'b1;
      end
      if (cfg_image.protect_enable && addr >= cfg_image.protect_low &&
          addr <= cfg_image.protect_high) begin
         err = frame(KIND_ERR, CODE_PROTECTED, addr, 16'd0, 16'd0);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Returns 1 when the transaction gives a reply; updates the register image
   function automatic bit predict_reply(input req_type r, output rsp_type rsp);
      int unsigned lim;
      rsp_type     err;
      lim = table_limit();
      rsp = '0;
      case (r.mode)
         MODE_RD1: begin
            if (r.first_address >= lim)
               rsp = frame(KIND_ERR, CODE_BADADDR, r.first_address, 16'd0, 16'd0);
            else
               rsp = frame(KIND_RD1, r.first_address, reg_image[r.first_address], 16'd0, 16'd0);
         end
         MODE_RD2: begin
            if (r.first_address >= lim)
               rsp = frame(KIND_ERR, CODE_BADADDR, r.first_address, 16'd0, 16'd0);
            else if (r.second_address >= lim)
               rsp = frame(KIND_ERR, CODE_BADADDR, r.second_address, 16'd0, 16'd0);
            else
               rsp = frame(KIND_RD2, r.first_address, reg_image[r.first_address],
                           r.second_address, reg_image[r.second_address]);
         end
         MODE_WR1: begin
            if (r.block_state_changes)
               rsp = frame(KIND_ERR, CODE_BLOCKED, 16'd0, 16'd0, 16'd0);
            else if (write_refused(r.first_address, err))
               rsp = err;
            else begin
               reg_image[r.first_address] = r.first_data;
               rsp = frame(KIND_WR1, r.first_address, 16'd0, 16'd0, 16'd0);
            end
         end
         MODE_WR2: begin
            if (r.block_state_changes)
               rsp = frame(KIND_ERR, CODE_BLOCKED, 16'd0, 16'd0, 16'd0);
            else if (write_refused(r.first_address, err))
               rsp = err;
            else if (write_refused(r.second_address, err))
               rsp = err;
            else begin
               // second write lands last, so it wins on equal addresses
               reg_image[r.first_address]  = r.first_data;
               reg_image[r.second_address] = r.second_data;
               rsp = frame(KIND_WR2, r.first_address, r.second_address, 16'd0, 16'd0);
            end
         end
         MODE_PING: rsp = frame(KIND_PING, r.first_address, r.first_data,
                                r.second_address, r.second_data);
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic directed_row_type req_row(input logic [2:0] m, input logic blk,
                                                input logic [15:0] a1, d1, a2, d2);
      directed_row_type row;
      row = '{csr_idx: CSR_TABLE_SIZE, default: '0};
      row.request = {m, blk, a1, d1, a2, d2};
      return row;
   endfunction

   function automatic directed_row_type known_row(input logic [2:0] m, input logic blk,
                                                  input logic [15:0] a1, d1, a2, d2,
                                                  input rsp_type want);
      directed_row_type row;
      row = req_row(m, blk, a1, d1, a2, d2);
      row.typed = 1'b1;
      row.reply = want;
      return row;
   endfunction

   function automatic directed_row_type csr_row(input csr_index_type idx,
                                                input logic [31:0] value);
      directed_row_type row;
      row = '{csr_idx: CSR_TABLE_SIZE, default: '0};
      row.is_csr    = 1'b1;
      row.csr_idx   = idx;
      row.csr_value = value;
      return row;
   endfunction

   // Biased towards the valid range, the protected edges and the size boundary
   function automatic logic [15:0] pick_address();
      int unsigned lim;
      int unsigned roll;
      lim = table_limit();
      roll = $urandom_range(99);
      if (roll < 55 && lim != 0) return 16'($urandom_range(0, lim - 1));
      if (roll < 70) begin
         case ($urandom_range(0, 3))
            0:       return cfg_image.protect_low - 16'd1;
            1:       return cfg_image.protect_low;
            2:       return cfg_image.protect_high;
            default: return cfg_image.protect_high + 16'd1;
         endcase
      end
      if (roll < 85) return 16'(lim + $urandom_range(0, 3) - 2);
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_data();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return 16'h0000;
      if (roll < 20) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic req_type random_request();
      req_type r;
      if ($urandom_range(99) < 4)
         r.mode = 3'(MODE_SPARE_A + $urandom_range(0, 2));
      else
         r.mode = LIVE_MODES[$urandom_range(0, 4)];
      r.block_state_changes = ($urandom_range(99) < 12);
      r.first_address  = pick_address();
      r.first_data     = pick_data();
      r.second_address = ($urandom_range(99) < 12) ? r.first_address : pick_address();
      r.second_data    = pick_data();
      return r;
   endfunction

   // ---------------------------------------------------------------- request side

   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_reply);
      rsp_type want;
      req_ch.valid               <= 1'b1;
      req_ch.mode                <= r.mode;
      req_ch.block_state_changes <= r.block_state_changes;
      req_ch.first_address       <= r.first_address;
      req_ch.first_data          <= r.first_data;
      req_ch.second_address      <= r.second_address;
      req_ch.second_data         <= r.second_data;
      do @(posedge clock); while (!req_ch.ready);
      if (predict_reply(r, want))
         expected_replies.push_back(typed ? typed_reply : want);
   endtask

   task automatic idle_gap();
      if (allow_gaps && $urandom_range(99) < 37) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Drop valid, wait for every outstanding reply, then let the block settle
   task automatic quiesce(input int unsigned tail);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- configuration port

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * idx);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         CSR_TABLE_SIZE:     cfg_image.table_size     = value[8:0];
         CSR_PROTECT_ENABLE: cfg_image.protect_enable = value[0];
         CSR_PROTECT_LOW:    cfg_image.protect_low    = value[15:0];
         CSR_PROTECT_HIGH:   cfg_image.protect_high   = value[15:0];
         default: ;
      endcase
   endtask

   task automatic csr_check(input csr_index_type idx);
      logic [31:0] want;
      case (idx)
         CSR_TABLE_SIZE:     want = 32'(cfg_image.table_size);
         CSR_PROTECT_ENABLE: want = 32'(cfg_image.protect_enable);
         CSR_PROTECT_LOW:    want = 32'(cfg_image.protect_low);
         default:            want = 32'(cfg_image.protect_high);
      endcase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(4 * idx);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $display("%0t: register %s read back, expected %h, actual %h",
                  $time, idx.name(), want, csr_prdata);
         error_count++;
      end
   endtask

   task automatic csr_idle();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check_all();
      csr_check(CSR_TABLE_SIZE);
      csr_check(CSR_PROTECT_ENABLE);
      csr_check(CSR_PROTECT_LOW);
      csr_check(CSR_PROTECT_HIGH);
      csr_idle();
   endtask

   // ---------------------------------------------------------------- reply side

   // Reply ready: random stalls, none while gaps are switched off
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !allow_gaps || ($urandom_range(99) >= 37);
      end
   end

   function automatic bit field_ok(input string name, input logic [15:0] want, got);
      if (got !== want) begin
         $display("%0t: reply %s mismatch, expected %h, actual %h", $time, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Compare each accepted reply with the oldest expectation
   always @(posedge clock) begin : reply_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.reply_kind, rsp_ch.word_zero, rsp_ch.word_one,
                rsp_ch.word_two, rsp_ch.word_three};
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected reply, expected none, actual %h", $time, got);
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            if (!(field_ok("reply_kind", 16'(want.reply_kind), 16'(got.reply_kind)) &
                  field_ok("word_zero", want.word_zero, got.word_zero) &
                  field_ok("word_one", want.word_one, got.word_one) &
                  field_ok("word_two", want.word_two, got.word_two) &
                  field_ok("word_three", want.word_three, got.word_three)))
               error_count++;
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_psel || (req_ch.valid && req_ch.ready) ||
             (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transaction for %0d cycles, %0d replies outstanding",
               $time, STALL_LIMIT, expected_replies.size());
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      int unsigned live;
      req_type     r;

      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_ch.valid               = 1'b0;
      req_ch.mode                = MODE_RD1;
      req_ch.block_state_changes = 1'b0;
      req_ch.first_address       = '0;
      req_ch.first_data          = '0;
      req_ch.second_address      = '0;
      req_ch.second_data         = '0;
      allow_gaps  = 1'b1;
      error_count = 0;
      foreach (reg_image[i]) reg_image[i] = '0;
      cfg_image = '{table_size: 9'd256, protect_enable: 1'b0, protect_low: 16'd0,
                    protect_high: 16'd0};

      // Directed part, at reset configuration unless a row says otherwise
      directed.push_back(known_row(MODE_RD1, 1'b0, 16'd0, 16'h1111, 16'd0, 16'd0,
                         frame(KIND_RD1, 16'd0, 16'd0, 16'd0, 16'd0)));
      directed.push_back(known_row(MODE_RD1, 1'b0, 16'd256, 16'd0, 16'd0, 16'd0,
                         frame(KIND_ERR, CODE_BADADDR, 16'd256, 16'd0, 16'd0)));
      directed.push_back(known_row(MODE_RD2, 1'b0, 16'd0, 16'd0, 16'd255, 16'd0,
                         frame(KIND_RD2, 16'd0, 16'd0, 16'd255, 16'd0)));
      directed.push_back(known_row(MODE_RD2, 1'b0, 16'd300, 16'd0, 16'd5, 16'd0,
                         frame(KIND_ERR, CODE_BADADDR, 16'd300, 16'd0, 16'd0)));
      directed.push_back(known_row(MODE_RD2, 1'b0, 16'd5, 16'd0, 16'hFFFF, 16'd0,
                         frame(KIND_ERR, CODE_BADADDR, 16'hFFFF, 16'd0, 16'd0)));
      directed.push_back(known_row(MODE_WR1, 1'b1, 16'd0, 16'hFFFF, 16'd0, 16'd0,
                         frame(KIND_ERR, CODE_BLOCKED, 16'd0, 16'd0, 16'd0)));
      directed.push_back(known_row(MODE_WR2, 1'b1, 16'd1, 16'hFFFF, 16'd2, 16'hFFFF,
                         frame(KIND_ERR, CODE_BLOCKED, 16'd0, 16'd0, 16'd0)));
      directed.push_back(known_row(MODE_WR1, 1'b0, 16'd0, 16'hFFFF, 16'd0, 16'd0,
                         frame(KIND_WR1, 16'd0, 16'd0, 16'd0, 16'd0)));
      directed.push_back(known_row(MODE_WR1, 1'b0, 16'd255, 16'hA5A5, 16'd0, 16'd0,
                         frame(KIND_WR1, 16'd255, 16'd0, 16'd0, 16'd0)));
      directed.push_back(known_row(MODE_RD2, 1'b0, 16'd0, 16'd0, 16'd255, 16'd0,
                         frame(KIND_RD2, 16'd0, 16'hFFFF, 16'd255, 16'hA5A5)));
      // double write to one address: the second data must stick
      directed.push_back(known_row(MODE_WR2, 1'b0, 16'd7, 16'h1234, 16'd7, 16'h5678,
                         frame(KIND_WR2, 16'd7, 16'd7, 16'd0, 16'd0)));
      directed.push_back(known_row(MODE_RD1, 1'b1, 16'd7, 16'd0, 16'd0, 16'd0,
                         frame(KIND_RD1, 16'd7, 16'h5678, 16'd0, 16'd0)));
      directed.push_back(known_row(MODE_WR2, 1'b0, 16'd3, 16'h0001, 16'hFFFF, 16'h0002,
                         frame(KIND_ERR, CODE_BADADDR, 16'hFFFF, 16'd0, 16'd0)));
      directed.push_back(known_row(MODE_PING, 1'b1, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA,
                         frame(KIND_PING, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA)));
      directed.push_back(known_row(MODE_PING, 1'b0, 16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
                         frame(KIND_PING, 16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555)));
      // ignored modes: no reply, no state change
      directed.push_back(req_row(MODE_SPARE_A, 1'b0, 16'd1, 16'hFFFF, 16'd2, 16'hFFFF));
      directed.push_back(req_row(MODE_SPARE_B, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      directed.push_back(req_row(MODE_SPARE_C, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
      // protected range 16..31
      directed.push_back(csr_row(CSR_PROTECT_LOW, 32'd16));
      directed.push_back(csr_row(CSR_PROTECT_HIGH, 32'd31));
      directed.push_back(csr_row(CSR_PROTECT_ENABLE, 32'd1));
      directed.push_back(known_row(MODE_WR1, 1'b0, 16'd16, 16'h1111, 16'd0, 16'd0,
                         frame(KIND_ERR, CODE_PROTECTED, 16'd16, 16'd0, 16'd0)));
      directed.push_back(known_row(MODE_WR1, 1'b0, 16'd31, 16'h1111, 16'd0, 16'd0,
                         frame(KIND_ERR, CODE_PROTECTED, 16'd31, 16'd0, 16'd0)));
      directed.push_back(known_row(MODE_WR2, 1'b0, 16'd32, 16'h2222, 16'd20, 16'h3333,
                         frame(KIND_ERR, CODE_PROTECTED, 16'd20, 16'd0, 16'd0)));
      directed.push_back(known_row(MODE_WR2, 1'b0, 16'd300, 16'h2222, 16'd20, 16'h3333,
                         frame(KIND_ERR, CODE_BADADDR, 16'd300, 16'd0, 16'd0)));
      directed.push_back(req_row(MODE_WR2, 1'b0, 16'd15, 16'hBEEF, 16'd32, 16'hCAFE));
      directed.push_back(req_row(MODE_RD2, 1'b0, 16'd15, 16'd0, 16'd32, 16'd0));
      // empty table: every address is refused
      directed.push_back(csr_row(CSR_TABLE_SIZE, 32'd0));
      directed.push_back(known_row(MODE_RD1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0,
                         frame(KIND_ERR, CODE_BADADDR, 16'd0, 16'd0, 16'd0)));

      // Random phases: size, enable, low, high (raw values, masked by the block)
      phase_settings = '{
         '{32'd256,        32'd0,        32'd0,        32'd0},
         '{32'd16,         32'd1,        32'd4,        32'd9},
         '{32'd0,          32'd1,        32'd0,        32'h0000_FFFF},
         '{32'd511,        32'd1,        32'h0000_FFFF, 32'd0},
         '{32'hFFFF_FF2C,  32'hFFFF_FFFE, 32'hABCD_0000, 32'h0001_FFFF},
         '{32'd1,          32'd1,        32'd0,        32'd0},
         '{32'd2,          32'd1,        32'd1,        32'd1},
         '{32'd256,        32'd1,        32'd200,      32'd255},
         '{32'd64,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults after reset
      csr_check_all();

      foreach (directed[i]) begin
         if (directed[i].is_csr) begin
            quiesce(SETTLE_CYCLES);
            csr_write(directed[i].csr_idx, directed[i].csr_value);
            csr_idle();
         end else begin
            send_request(directed[i].request, directed[i].typed, directed[i].reply);
            idle_gap();
         end
      end

      foreach (phase_settings[p]) begin
         quiesce(SETTLE_CYCLES);
         csr_write(CSR_TABLE_SIZE, phase_settings[p].size_raw);
         csr_write(CSR_PROTECT_ENABLE, phase_settings[p].enable_raw);
         csr_write(CSR_PROTECT_LOW, phase_settings[p].low_raw);
         csr_write(CSR_PROTECT_HIGH, phase_settings[p].high_raw);
         csr_idle();
         csr_check_all();
         allow_gaps = (p != NO_GAP_PHASE);
         live = 0;
         while (live < PHASE_ITEMS) begin
            r = random_request();
            if (r.mode <= MODE_PING) live++;
            send_request(r, 1'b0, '0);
            idle_gap();
         end
      end

      allow_gaps = 1'b1;
      quiesce(END_CYCLES);
      if (error_count == 0 && expected_replies.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
